@@ hdl/shfc_pkg.sv @@
package shfc_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned StateW  = 32;

  typedef enum logic [1:0] {
    REG_FREQ_SHIFT  = 2'd0,
    REG_STAGE_COUNT = 2'd1,
    REG_WET_GAIN    = 2'd2,
    REG_DRY_GAIN    = 2'd3
  } cfg_reg_e;

  // one memory row: both channels of one stage
  typedef struct packed {
    logic signed [StateW-1:0] level_l;
    logic signed [StateW-1:0] slope_l;
    logic signed [StateW-1:0] level_r;
    logic signed [StateW-1:0] slope_r;
  } stage_row_t;

  typedef struct packed {
    logic signed [StateW-1:0] nl;
    logic signed [StateW-1:0] ns;
  } stage_res_t;

  function automatic logic signed [StateW-1:0] sat32(input logic signed [35:0] v);
    logic signed [StateW-1:0] r;
    if (v[35:31] != {5{v[35]}}) begin
      r = v[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [48:0] v);
    logic signed [SampleW-1:0] r;
    if (v[48:23] != {26{v[48]}}) begin
      r = v[48] ? 24'sh80_0000 : 24'sh7F_FFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // one holt stage update, all shifts arithmetic
  function automatic stage_res_t stage_upd(input logic signed [StateW-1:0] x,
                                           input logic signed [StateW-1:0] l,
                                           input logic signed [StateW-1:0] s,
                                           input logic [4:0] sh);
    logic signed [32:0] ls;
    logic signed [33:0] d;
    logic signed [33:0] ns;
    logic signed [35:0] nl;
    stage_res_t r;
    ls = 33'(l) + 33'(s);
    d  = 34'(x) - 34'(l) + 34'(s);
    ns = d >>> (sh + 5'd1);
    nl = 36'(x >>> sh) + 36'(ls) - 36'(ls >>> sh);
    r.nl = sat32(nl);
    r.ns = sat32(36'(ns));
    return r;
  endfunction

endpackage

@@ hdl/shfc_ram.sv @@
module shfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/stereo_holt_filter_cascade.sv @@
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   sample_left_i, sample_right_i
// out      source     out_valid_o / out_stall_i out_left_o, out_right_o
// cfg      sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a word passes through the accept step, which also issues the first read, one step per
// active stage on the stage memory's read-modify-write port, a multiply step and a
// mix step. reset clears the control and configuration registers and the
// per-stage valid bits, so all stage state reads as zero with no clearing pass.
// a stalled output holds the finished word; the next word is taken meanwhile and
// waits in the mix state until the output register frees up.
module stereo_holt_filter_cascade #(
  parameter int unsigned MAX_STAGES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [shfc_pkg::SampleW-1:0] sample_left_i,
  input  logic signed [shfc_pkg::SampleW-1:0] sample_right_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [shfc_pkg::SampleW-1:0] out_left_o,
  output logic signed [shfc_pkg::SampleW-1:0] out_right_o,
  input  logic                                cfg_we_i,
  input  shfc_pkg::cfg_reg_e                  cfg_idx_i,
  input  logic [15:0]                         cfg_data_i
);

  import shfc_pkg::*;

  localparam int unsigned IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_STAGES + 1);
  localparam int unsigned RowW = $bits(stage_row_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_STAGE = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_MIX   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]         freq_shift_q;
  logic [3:0]         stage_count_q;
  logic signed [15:0] wet_gain_q;
  logic [15:0]        dry_gain_q;

  logic [CW-1:0]         idx_q, idx_d, n_q, n_d, n_eff;
  logic [4:0]            sh_q, sh_d, sh_eff;
  logic [MAX_STAGES-1:0] vld_q, vld_d;
  logic signed [StateW-1:0]  x_l_q, x_l_d, x_r_q, x_r_d;
  logic signed [SampleW-1:0] in_l_q, in_l_d, in_r_q, in_r_d;
  logic signed [47:0] pw_l_q, pw_r_q;
  logic signed [40:0] pd_l_q, pd_r_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_l_q, out_l_d, out_r_q, out_r_d;

  logic            ram_we;
  logic [IW-1:0]   ram_raddr;
  logic [RowW-1:0] ram_rdata;
  stage_row_t      row_rd, row_wr;
  stage_res_t      res_l, res_r;
  logic [CW-1:0]   idx_nxt;
  logic            in_acc;

  shfc_ram #(
    .WIDTH (RowW),
    .DEPTH (MAX_STAGES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (row_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sh_eff = (freq_shift_q > 5'd16) ? 5'd16 : freq_shift_q;
  assign n_eff  = (32'(stage_count_q) > MAX_STAGES) ? CW'(MAX_STAGES) : CW'(stage_count_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

  // a stage never written since reset reads as zero
  assign row_rd  = vld_q[idx_q[IW-1:0]] ? stage_row_t'(ram_rdata) : '0;
  assign res_l   = stage_upd(x_l_q, row_rd.level_l, row_rd.slope_l, sh_q);
  assign res_r   = stage_upd(x_r_q, row_rd.level_r, row_rd.slope_r, sh_q);
  assign idx_nxt = idx_q + CW'(1);

  always_comb begin
    row_wr.level_l = res_l.nl;
    row_wr.slope_l = res_l.ns;
    row_wr.level_r = res_r.nl;
    row_wr.slope_r = res_r.ns;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    sh_d        = sh_q;
    vld_d       = vld_q;
    x_l_d       = x_l_q;
    x_r_d       = x_r_q;
    in_l_d      = in_l_q;
    in_r_d      = in_r_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    ram_we      = 1'b0;
    ram_raddr   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          in_l_d  = sample_left_i;
          in_r_d  = sample_right_i;
          x_l_d   = 32'(sample_left_i);
          x_r_d   = 32'(sample_right_i);
          sh_d    = sh_eff;
          n_d     = n_eff;
          idx_d   = '0;
          state_d = (n_eff == '0) ? ST_MUL : ST_STAGE;
        end
      end
      ST_STAGE: begin
        ram_we                 = 1'b1;
        vld_d[idx_q[IW-1:0]]   = 1'b1;
        x_l_d                  = res_l.nl;
        x_r_d                  = res_r.nl;
        idx_d                  = idx_nxt;
        if (idx_nxt == n_q) begin
          state_d = ST_MUL;
        end else begin
          ram_raddr = idx_nxt[IW-1:0];
        end
      end
      ST_MUL: begin
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_l_d     = sat24((49'(pw_l_q) + 49'(pd_l_q)) >>> 15);
          out_r_d     = sat24((49'(pw_r_q) + 49'(pd_r_q)) >>> 15);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      n_q           <= '0;
      sh_q          <= '0;
      vld_q         <= '0;
      out_valid_q   <= 1'b0;
      freq_shift_q  <= 5'd5;
      stage_count_q <= 4'd4;
      wet_gain_q    <= 16'sd32767;
      dry_gain_q    <= 16'd0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      sh_q        <= sh_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FREQ_SHIFT:  freq_shift_q  <= cfg_data_i[4:0];
          REG_STAGE_COUNT: stage_count_q <= cfg_data_i[3:0];
          REG_WET_GAIN:    wet_gain_q    <= $signed(cfg_data_i);
          REG_DRY_GAIN:    dry_gain_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_l_q   <= x_l_d;
    x_r_q   <= x_r_d;
    in_l_q  <= in_l_d;
    in_r_q  <= in_r_d;
    out_l_q <= out_l_d;
    out_r_q <= out_r_d;
    if (state_q == ST_MUL) begin
      pw_l_q <= 48'(x_l_q) * 48'(wet_gain_q);
      pw_r_q <= 48'(x_r_q) * 48'(wet_gain_q);
      pd_l_q <= 41'(in_l_q) * $signed({25'd0, dry_gain_q});
      pd_r_q <= 41'(in_r_q) * $signed({25'd0, dry_gain_q});
    end
  end

endmodule
